### rtl/cpue_pkg.sv
// ----------------------------------------------------------------------------
// cpue_pkg
// Shared widths, format codes and types for the code point unit encoder.
// ----------------------------------------------------------------------------
package cpue_pkg;

	localparam int CP_W       = 21;
	localparam int FMT_W      = 2;
	localparam int MAX_UNITS  = 4;
	localparam int IDX_W      = 2;
	localparam int CNT_W      = 3;

	localparam logic [FMT_W-1:0] FMT_ASCII = 2'd0;
	localparam logic [FMT_W-1:0] FMT_UTF8  = 2'd1;
	localparam logic [FMT_W-1:0] FMT_UTF16 = 2'd2;
	localparam logic [FMT_W-1:0] FMT_UTF32 = 2'd3;

	localparam logic [CP_W-1:0] ASCII_SUBST = CP_W'(8'h3f);

	// up to four units for one code point, unit 0 leaves first
	typedef struct packed {
		logic [MAX_UNITS-1:0][CP_W-1:0] unit;
		logic [CNT_W-1:0]               count;
	} enc_t;

endpackage

### rtl/cpue_if.sv
// ----------------------------------------------------------------------------
// cpue_if
// Valid/ready channels: code points in, code units out.
// ----------------------------------------------------------------------------
interface cpue_cp_if
	import cpue_pkg::*;
	();
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;

	modport source (output valid, output code_point, input ready);
	modport sink   (input valid, input code_point, output ready);
endinterface

interface cpue_unit_if
	import cpue_pkg::*;
	();
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_unit;
	logic            last_unit;

	modport source (output valid, output code_unit, output last_unit, input ready);
	modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

### rtl/cpue_encode.sv
// ----------------------------------------------------------------------------
// cpue_encode
// Combinational encoding of one code point into its units for the chosen
// output format.
// ----------------------------------------------------------------------------
module cpue_encode
	import cpue_pkg::*;
(
	input  logic [CP_W-1:0]  code_point,
	input  logic [FMT_W-1:0] output_format,
	output enc_t             enc
);

	logic [CP_W-1:0] v;
	logic            bmp_ok;
	logic            supp_ok;

	assign v       = code_point - CP_W'(21'h10000);
	assign bmp_ok  = (code_point < CP_W'(21'hd800)) ||
	                 ((code_point >= CP_W'(21'he000)) && (code_point < CP_W'(21'h10000)));
	assign supp_ok = (code_point >= CP_W'(21'h10000)) && (code_point < CP_W'(21'h110000));

	always_comb begin
		enc.unit  = '0;
		enc.count = CNT_W'(1);
		case (output_format)
			FMT_ASCII: begin
				enc.unit[0] = (code_point > CP_W'(8'h7f)) ? ASCII_SUBST : code_point;
			end
			FMT_UTF8: begin
				if (code_point < CP_W'(12'h080)) begin
					enc.unit[0] = code_point;
				end else if (code_point < CP_W'(12'h800)) begin
					enc.unit[0] = {13'd0, 3'b110, code_point[10:6]};
					enc.unit[1] = {13'd0, 2'b10, code_point[5:0]};
					enc.count   = CNT_W'(2);
				end else if (code_point < CP_W'(21'h10000)) begin
					enc.unit[0] = {13'd0, 4'b1110, code_point[15:12]};
					enc.unit[1] = {13'd0, 2'b10, code_point[11:6]};
					enc.unit[2] = {13'd0, 2'b10, code_point[5:0]};
					enc.count   = CNT_W'(3);
				end else begin
					// values past the Unicode range still get a four-byte form
					enc.unit[0] = {13'd0, 5'b11110, code_point[20:18]};
					enc.unit[1] = {13'd0, 2'b10, code_point[17:12]};
					enc.unit[2] = {13'd0, 2'b10, code_point[11:6]};
					enc.unit[3] = {13'd0, 2'b10, code_point[5:0]};
					enc.count   = CNT_W'(4);
				end
			end
			FMT_UTF16: begin
				if (bmp_ok) begin
					enc.unit[0] = code_point;
				end else if (supp_ok) begin
					enc.unit[0] = {5'd0, 6'b110110, v[19:10]};
					enc.unit[1] = {5'd0, 6'b110111, v[9:0]};
					enc.count   = CNT_W'(2);
				end else begin
					// lone surrogates and out-of-range values drop out
					enc.count   = '0;
				end
			end
			default: begin
				enc.unit[0] = code_point;
			end
		endcase
	end

endmodule

### rtl/code_point_unit_encoder.sv
// ----------------------------------------------------------------------------
// code_point_unit_encoder
// Encodes code points as ASCII, UTF-8, UTF-16 or UTF-32 code units.
// ----------------------------------------------------------------------------
//  channel   dir  payload                  handshake
//  cp_in     in   code_point[20:0]         valid/ready
//  unit_out  out  code_unit[20:0], last    valid/ready
//  cfg       in   cfg_wdata[1:0]           cfg_we, no back-pressure
//
//  Input register, then encoder into a unit buffer that drives the output.
//  One unit leaves per cycle while unit_out.ready is high; an item gives 1 to 4
//  units, and UTF-16 items that give no unit never make the buffer valid.
//  Reset sets the format to UTF-8 and empties both stages.
//  A stalled output holds the buffer; input still loads while the buffer's
//  last unit is being taken.
// ----------------------------------------------------------------------------
module code_point_unit_encoder
	import cpue_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [FMT_W-1:0] cfg_wdata,
	cpue_cp_if.sink          cp_in,
	cpue_unit_if.source      unit_out
);

	logic [FMT_W-1:0]               output_format_q;
	logic                           valid_s1;
	logic [CP_W-1:0]                code_point_s1;
	logic                           valid_s2;
	logic [MAX_UNITS-1:0][CP_W-1:0] unit_s2;
	logic [IDX_W-1:0]               idx_s2;
	logic [IDX_W-1:0]               last_idx_s2;
	enc_t                           enc;
	logic                           s2_last;
	logic                           s2_free;
	logic                           s1_move;
	logic                           out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_format_q <= FMT_UTF8;
		end else if (cfg_we) begin
			output_format_q <= cfg_wdata;
		end
	end

	cpue_encode u_encode (
		.code_point    (code_point_s1),
		.output_format (output_format_q),
		.enc           (enc)
	);

	assign out_take = valid_s2 && unit_out.ready;
	assign s2_last  = idx_s2 == last_idx_s2;
	assign s2_free  = !valid_s2 || (out_take && s2_last);
	assign s1_move  = valid_s1 && s2_free;
	assign cp_in.ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cp_in.ready) begin
			valid_s1 <= cp_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cp_in.ready && cp_in.valid) begin
			code_point_s1 <= cp_in.code_point;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
		end else if (s2_free) begin
			valid_s2 <= s1_move && (enc.count != '0);
			idx_s2   <= '0;
		end else if (out_take) begin
			idx_s2   <= idx_s2 + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			unit_s2     <= enc.unit;
			last_idx_s2 <= IDX_W'(enc.count - CNT_W'(1));
		end
	end

	assign unit_out.valid     = valid_s2;
	assign unit_out.code_unit = unit_s2[idx_s2];
	assign unit_out.last_unit = s2_last;

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> idx_s2 <= last_idx_s2)
		else $error("unit index past last unit");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && s2_last) |=> idx_s2 == '0)
		else $error("unit index not cleared after last unit");

	a_mid_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !(out_take && s2_last)) |-> !cp_in.ready)
		else $error("input taken while both stages are busy");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && !s2_last) |=> valid_s2 && idx_s2 == $past(idx_s2) + IDX_W'(1))
		else $error("unit index did not advance");
`endif

endmodule

### tb/tb_code_point_unit_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_code_point_unit_encoder
// Feeds code points through the valid/ready input channel under all four
// output formats. A predictor builds the code units due for each accepted
// item. Every unit that leaves the block is checked in order against them.
// Both sides idle at random, and the output may be held off.
// ----------------------------------------------------------------------------
module tb_code_point_unit_encoder;
	import cpue_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int SEG_ITEMS    = 25;
	localparam int NUM_SEGS     = 8;

	localparam logic [CP_W-1:0] ASCII_TOP  = 21'h00007f;
	localparam logic [CP_W-1:0] TWO_BYTE   = 21'h000080;
	localparam logic [CP_W-1:0] THREE_BYTE = 21'h000800;
	localparam logic [CP_W-1:0] SURR_BASE  = 21'h00d800;
	localparam logic [CP_W-1:0] SURR_END   = 21'h00e000;
	localparam logic [CP_W-1:0] PLANE1     = 21'h010000;
	localparam logic [CP_W-1:0] BEYOND_MAX = 21'h110000;
	localparam logic [CP_W-1:0] LOW_SURR   = 21'h00dc00;

	typedef struct {
		logic [CP_W-1:0] code_unit;
		logic            last_unit;
	} unit_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [FMT_W-1:0] cfg_wdata;

	cpue_cp_if   cp_bus ();
	cpue_unit_if unit_bus ();

	code_point_unit_encoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cp_in    (cp_bus),
		.unit_out (unit_bus)
	);

	logic [CP_W-1:0]  pending_cps [$];
	unit_t            expected_units [$];
	logic [FMT_W-1:0] fmt_shadow;
	int               send_idle_pct;
	int               recv_idle_pct;
	int               errors;
	int               items_sent;
	int               units_checked;
	int               cycle_count;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [CP_W-1:0] got,
			input logic [CP_W-1:0] want);
		$display("MISMATCH %s: got %h want %h (format %0d, item %0d)",
			what, got, want, fmt_shadow, items_sent);
		errors++;
	endtask

	task automatic push_unit(input logic [CP_W-1:0] unit, input logic last);
		unit_t u;
		u.code_unit = unit;
		u.last_unit = last;
		expected_units.push_back(u);
	endtask

	// units due for one code point under the current format
	task automatic predict_units(input logic [CP_W-1:0] cp);
		logic [CP_W-1:0] v;
		v = cp - PLANE1;
		case (fmt_shadow)
			FMT_ASCII: begin
				push_unit((cp > ASCII_TOP) ? ASCII_SUBST : cp, 1'b1);
			end
			FMT_UTF8: begin
				if (cp < TWO_BYTE) begin
					push_unit(cp, 1'b1);
				end else if (cp < THREE_BYTE) begin
					push_unit(CP_W'({3'b110, cp[10:6]}), 1'b0);
					push_unit(CP_W'({2'b10, cp[5:0]}), 1'b1);
				end else if (cp < PLANE1) begin
					// surrogates go out as plain three-byte sequences
					push_unit(CP_W'({4'b1110, cp[15:12]}), 1'b0);
					push_unit(CP_W'({2'b10, cp[11:6]}), 1'b0);
					push_unit(CP_W'({2'b10, cp[5:0]}), 1'b1);
				end else begin
					// above 0x10FFFF the lead byte runs up to 0xF7
					push_unit(CP_W'({5'b11110, cp[20:18]}), 1'b0);
					push_unit(CP_W'({2'b10, cp[17:12]}), 1'b0);
					push_unit(CP_W'({2'b10, cp[11:6]}), 1'b0);
					push_unit(CP_W'({2'b10, cp[5:0]}), 1'b1);
				end
			end
			FMT_UTF16: begin
				if (cp < SURR_BASE || (cp >= SURR_END && cp < PLANE1)) begin
					push_unit(cp, 1'b1);
				end else if (cp >= PLANE1 && cp < BEYOND_MAX) begin
					push_unit(SURR_BASE + CP_W'(v[19:10]), 1'b0);
					push_unit(LOW_SURR + CP_W'(v[9:0]), 1'b1);
				end
				// surrogates and out-of-range values give nothing
			end
			default: begin
				push_unit(cp, 1'b1);
			end
		endcase
	endtask

	function automatic logic [CP_W-1:0] random_code_point();
		case ($urandom_range(0, 6))
			0:       return CP_W'($urandom_range(0, 'h7f));
			1:       return CP_W'($urandom_range('h80, 'h7ff));
			2:       return CP_W'($urandom_range('h800, 'hffff));
			3:       return CP_W'($urandom_range('hd800, 'hdfff));
			4:       return CP_W'($urandom_range('h10000, 'h10ffff));
			5:       return CP_W'($urandom_range('h110000, 'h1fffff));
			default: return CP_W'($urandom());
		endcase
	endfunction

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			cp_bus.valid <= 1'b0;
		end else begin
			if (cp_bus.valid && cp_bus.ready) begin
				predict_units(cp_bus.code_point);
				items_sent++;
			end
			if (!cp_bus.valid || cp_bus.ready) begin
				if (pending_cps.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cp_bus.valid      <= 1'b1;
					cp_bus.code_point <= pending_cps.pop_front();
				end else begin
					cp_bus.valid <= 1'b0;
				end
			end
		end
	end

	// output monitor and checker
	always @(posedge clk) begin : unit_monitor
		unit_t want;
		if (!arst_n) begin
			unit_bus.ready <= 1'b0;
		end else begin
			if (unit_bus.valid && unit_bus.ready) begin
				if (expected_units.size() == 0) begin
					report_mismatch("unit with nothing due", unit_bus.code_unit, '0);
				end else begin
					want = expected_units.pop_front();
					if (unit_bus.code_unit !== want.code_unit)
						report_mismatch("code_unit", unit_bus.code_unit, want.code_unit);
					if (unit_bus.last_unit !== want.last_unit)
						report_mismatch("last_unit", CP_W'(unit_bus.last_unit),
							CP_W'(want.last_unit));
				end
				units_checked++;
			end
			unit_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d units outstanding",
				cycle_count, expected_units.size());
			$display("code_point_unit_encoder test failed");
			$finish;
		end
	end

	// wait until every item is in and every unit is out, then let any
	// unit-less item clear the pipeline
	task automatic drain();
		while (pending_cps.size() != 0 || cp_bus.valid || expected_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_format(input logic [FMT_W-1:0] fmt);
		@(posedge clk);
		cfg_we     <= 1'b1;
		cfg_wdata  <= fmt;
		fmt_shadow = fmt;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send(input logic [CP_W-1:0] cp);
		pending_cps.push_back(cp);
	endtask

	initial begin
		logic [FMT_W-1:0] seg_fmt;
		clk               = 1'b0;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		cp_bus.valid      = 1'b0;
		cp_bus.code_point = '0;
		unit_bus.ready    = 1'b0;
		fmt_shadow        = FMT_UTF8;
		send_idle_pct     = 28;
		recv_idle_pct     = 76;
		errors            = 0;
		items_sent        = 0;
		units_checked     = 0;
		cycle_count       = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset format is UTF-8: range edges, surrogates, beyond Unicode
		send(21'h000000); send(21'h00007f); send(21'h000080); send(21'h0007ff);
		send(21'h000800); send(21'h00d800); send(21'h00ffff); send(21'h010000);
		send(21'h10ffff); send(21'h110000); send(21'h1fffff);
		drain();

		write_format(FMT_ASCII);
		send(21'h00007f); send(21'h000080); send(21'h1fffff);
		drain();

		write_format(FMT_UTF16);
		send(21'h000000); send(21'h00d7ff); send(21'h00d800); send(21'h00dfff);
		send(21'h00e000); send(21'h010000); send(21'h10ffff); send(21'h110000);
		send(21'h1fffff);
		drain();

		write_format(FMT_UTF32);
		send(21'h000000); send(21'h1fffff);
		drain();

		for (int s = 0; s < NUM_SEGS; s++) begin
			case (s)
				0, 5:    seg_fmt = FMT_UTF8;
				1, 4, 7: seg_fmt = FMT_UTF16;
				2, 6:    seg_fmt = FMT_ASCII;
				default: seg_fmt = FMT_UTF32;
			endcase
			if (s < 3) begin
				send_idle_pct = 28;
				recv_idle_pct = 76;
			end else if (s < 6) begin
				send_idle_pct = 76;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_format(seg_fmt);
			for (int i = 0; i < SEG_ITEMS; i++) begin
				// hold the sender back once until the output is empty
				if (s == 4 && i == SEG_ITEMS / 2)
					drain();
				send(random_code_point());
			end
			drain();
		end

		if (expected_units.size() != 0)
			report_mismatch("units never seen", CP_W'(expected_units.size()), '0);

		$display("Ran %0d code points through all four formats, %0d units checked,",
			items_sent, units_checked);
		$display("with idling on either side in turn and none at the end.");
		if (errors == 0) begin
			$display("code_point_unit_encoder test passed");
		end else begin
			$display("code_point_unit_encoder test failed");
		end
		$finish;
	end

endmodule

### sim.f
rtl/cpue_pkg.sv
rtl/cpue_if.sv
rtl/cpue_encode.sv
rtl/code_point_unit_encoder.sv
tb/tb_code_point_unit_encoder.sv
